// ===== sv/kpse_pkg.sv =====
// Shared types, constants and helpers for the keypad scanner and number entry block.
package kpse_pkg;

   localparam int COL_W     = 4;
   localparam int ROW_W     = 4;
   localparam int POS_W     = 4;
   localparam int CODE_W    = 7;
   localparam int TICKS_W   = 20;
   localparam int KEYIDX_W  = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 20;
   localparam int NUM_OUT_W = 32;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;

   // Cycles the divide-by-ten unit needs after a number update.
   localparam int DIV_CYCLES = 4;

   typedef logic [CODE_W-1:0] key_code_type;

   localparam key_code_type MAX_DIGIT = 7'd9;

   localparam key_code_type KEY_TABLE [0:15] = '{
      7'd1,  7'd2, 7'd3,  7'd65,
      7'd4,  7'd5, 7'd6,  7'd66,
      7'd7,  7'd8, 7'd9,  7'd67,
      7'd12, 7'd0, 7'd14, 7'd15
   };

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEBOUNCE_TICKS = 2'd0,
      CSR_ENTER_KEY      = 2'd1,
      CSR_BACKSPACE_KEY  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_WAIT_PRESS   = 3'd0,
      PH_DEB_PRESS    = 3'd1,
      PH_SCAN         = 3'd2,
      PH_WAIT_RELEASE = 3'd3,
      PH_DEB_RELEASE  = 3'd4
   } phase_type;

   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] pos;
      key_code_type     code;
   } key_event_type;

   typedef struct packed {
      logic [3:0] quo;
      logic [3:0] rem;
   } div_digit_type;

   // One radix-16 long-division step by ten: v = {remainder, next nibble}, v < 160.
   function automatic div_digit_type div10_digit(input logic [7:0] v);
      logic [15:0]   prod;
      logic [7:0]    q8;
      logic [7:0]    r8;
      div_digit_type res;
      prod = 16'(v) * 16'd205;
      q8   = {4'b0, prod[14:11]};
      r8   = v - (q8 << 3) - (q8 << 1);
      res.quo = prod[14:11];
      res.rem = r8[3:0];
      return res;
   endfunction

endpackage

// ===== sv/kpse_div10.sv =====
// Iterative divide-by-ten unit, DPC quotient nibbles per cycle; a new load restarts it.
module kpse_div10
   import kpse_pkg::*;
#(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic [NUMBER_WIDTH-1:0] load_value,
   output logic [NUMBER_WIDTH-1:0] quotient
);

   localparam int NDIG  = (NUMBER_WIDTH + 3) / 4;
   localparam int DPC   = (NDIG + DIV_CYCLES - 1) / DIV_CYCLES;
   localparam int PAD_W = 4 * DPC * DIV_CYCLES;
   localparam int CNT_W = $clog2(DIV_CYCLES + 1);

   logic [PAD_W-1:0] work_ff, work_in;
   logic [3:0]       rem_ff, rem_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      logic [PAD_W-1:0] w;
      logic [3:0]       r;
      div_digit_type    d;
      w = work_ff;
      r = rem_ff;
      d = '0;
      for (int k = 0; k < DPC; k++) begin
         d = div10_digit({r, w[PAD_W-1 -: 4]});
         r = d.rem;
         w = {w[PAD_W-5:0], d.quo};
      end
      if (load) begin
         work_in  = PAD_W'(load_value);
         rem_in   = '0;
         count_in = CNT_W'(DIV_CYCLES);
      end else if (count_ff != '0) begin
         work_in  = w;
         rem_in   = r;
         count_in = count_ff - 1'b1;
      end else begin
         work_in  = work_ff;
         rem_in   = rem_ff;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff  <= '0;
         rem_ff   <= '0;
         count_ff <= '0;
      end else begin
         work_ff  <= work_in;
         rem_ff   <= rem_in;
         count_ff <= count_in;
      end
   end

   assign quotient = work_ff[NUMBER_WIDTH-1:0];

endmodule

// ===== sv/kpse_number.sv =====
// Decimal number accumulator: digits, backspace and enter.
module kpse_number
   import kpse_pkg::*;
#(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  key_event_type        key_evt,
   input  logic [KEYIDX_W-1:0]  enter_key,
   input  logic [KEYIDX_W-1:0]  backspace_key,
   output logic                 number_ready,
   output logic [NUM_OUT_W-1:0] entered_number
);

   localparam int EXT_W = (NUMBER_WIDTH > NUM_OUT_W) ? NUMBER_WIDTH : NUM_OUT_W;

   logic [NUMBER_WIDTH-1:0] acc_ff, acc_in;
   logic [NUMBER_WIDTH-1:0] acc_div10;
   logic [EXT_W-1:0]        acc_ext;
   logic                    acc_load;

   kpse_div10 #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_div10 (
      .clock     (clock),
      .reset     (reset),
      .load      (acc_load),
      .load_value(acc_in),
      .quotient  (acc_div10)
   );

   assign acc_ext = EXT_W'(acc_ff);

   always_comb begin
      acc_in         = acc_ff;
      number_ready   = 1'b0;
      entered_number = '0;
      priority if (key_evt.pos == enter_key) begin
         number_ready   = 1'b1;
         entered_number = acc_ext[NUM_OUT_W-1:0];
         acc_in         = '0;
      end else if (key_evt.pos == backspace_key) begin
         acc_in = acc_div10;   // zero stays zero
      end else if (key_evt.code <= MAX_DIGIT) begin
         acc_in = (acc_ff << 3) + (acc_ff << 1) + NUMBER_WIDTH'(key_evt.code);
      end else begin
         acc_in = acc_ff;      // other keys leave the number alone
      end
      if (!key_evt.valid) begin
         acc_in         = acc_ff;
         number_ready   = 1'b0;
         entered_number = '0;
      end
   end

   assign acc_load = step && key_evt.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (acc_load) begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== sv/kpse_scan.sv =====
// Keypad scan state machine: press wait, debounce, row scan, release, debounce.
module kpse_scan
   import kpse_pkg::*;
#(
   parameter int DEBOUNCE_WIDTH = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [COL_W-1:0]   column_levels,
   input  logic [TICKS_W-1:0] debounce_ticks,
   output logic [ROW_W-1:0]   row_drive,
   output key_event_type      key_evt
);

   localparam int CMP_W = (DEBOUNCE_WIDTH > TICKS_W) ? DEBOUNCE_WIDTH : TICKS_W;

   phase_type                 phase_ff, phase_in;
   logic [DEBOUNCE_WIDTH-1:0] count_ff, count_in;
   logic [1:0]                row_ff, row_in;
   logic [POS_W-1:0]          key_ff, key_in;

   logic [COL_W-1:0] lows;
   logic [1:0]       low_col;
   logic             deb_done;

   assign lows = ~column_levels;

   always_comb begin
      priority if (lows[0]) low_col = 2'd0;
      else if (lows[1])     low_col = 2'd1;
      else if (lows[2])     low_col = 2'd2;
      else                  low_col = 2'd3;
   end

   // Counter saturation also ends a debounce wait.
   assign deb_done = (CMP_W'(count_ff) >= CMP_W'(debounce_ticks)) || (count_ff == '1);

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      row_in   = row_ff;
      key_in   = key_ff;
      unique case (phase_ff)
         PH_WAIT_PRESS: begin
            if (lows != '0) begin
               phase_in = PH_DEB_PRESS;
               count_in = '0;
            end
         end
         PH_DEB_PRESS: begin
            if (deb_done) begin
               phase_in = PH_SCAN;
               row_in   = '0;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         PH_SCAN: begin
            if (lows != '0) begin
               key_in   = {row_ff, low_col};
               phase_in = PH_WAIT_RELEASE;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         PH_WAIT_RELEASE: begin
            if (lows == '0) begin
               phase_in = PH_DEB_RELEASE;
               count_in = '0;
            end
         end
         PH_DEB_RELEASE: begin
            if (deb_done) begin
               phase_in = PH_WAIT_PRESS;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         default: phase_in = PH_WAIT_PRESS;
      endcase
   end

   // outputs
   always_comb begin
      row_drive = '1;
      unique case (phase_in)
         PH_SCAN, PH_WAIT_RELEASE, PH_DEB_RELEASE: row_drive[row_in] = 1'b0;
         default:                                  row_drive = '0;
      endcase
      key_evt = '0;
      if (phase_ff == PH_DEB_RELEASE && deb_done) begin
         key_evt.valid = 1'b1;
         key_evt.pos   = key_ff;
         key_evt.code  = KEY_TABLE[key_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_PRESS;
         count_ff <= '0;
         row_ff   <= '0;
         key_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         row_ff   <= row_in;
         key_ff   <= key_in;
      end
   end

endmodule

// ===== sv/keypad_scan_number_entry_core.sv =====
// Top level: 4x4 keypad scanner with decimal number entry, stream in and out.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: column_levels[3:0]
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: row_drive, key_position, key_code,
//          |     |                       |        entered_number; tuser: key_event,
//          |     |                       |        number_ready
//  csr     | in  | csr_we (no wait)      | csr_addr index, csr_wdata value
//
// One request per cycle sustained unless the response stalls; each request
// yields one response through the input register, then the result register.
// Reset: scan waits for a press with all rows low, number is zero, registers
// take their reset values (debounce 50000, enter key 14, backspace key 11).
// A stalled response holds in the result register; the input register still
// takes a request while the result waits, and fills up one request deep.
// Backspace uses a divide-by-ten unit that is reloaded and restarts at each number
// update; a new key event needs at least five requests, so it never waits.
module keypad_scan_number_entry_core
   import kpse_pkg::*;
#(
   parameter int NUMBER_WIDTH   = 32,
   parameter int DEBOUNCE_WIDTH = 20
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [3:0] column_levels, rest zero

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] row_drive, [7:4] key_position,
                                              // [14:8] key_code, [46:15] entered_number
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [0] key_event, [1] number_ready

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // config registers
   logic [TICKS_W-1:0]  deb_ticks_ff;
   logic [KEYIDX_W-1:0] enter_key_ff;
   logic [KEYIDX_W-1:0] bksp_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ticks_ff <= TICKS_W'(50000);
         enter_key_ff <= KEYIDX_W'(14);
         bksp_key_ff  <= KEYIDX_W'(11);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEBOUNCE_TICKS: deb_ticks_ff <= csr_wdata[TICKS_W-1:0];
            CSR_ENTER_KEY:      enter_key_ff <= csr_wdata[KEYIDX_W-1:0];
            CSR_BACKSPACE_KEY:  bksp_key_ff  <= csr_wdata[KEYIDX_W-1:0];
            default: ;   // unmapped index, ignored
         endcase
      end
   end

   // input register
   logic             in_valid_ff;
   logic [COL_W-1:0] in_cols_ff;
   logic             advance;

   assign advance    = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cols_ff <= req_tdata[COL_W-1:0];
      end
   end

   // per-request logic
   logic [ROW_W-1:0]     row_drive;
   key_event_type        key_evt;
   logic                 number_ready;
   logic [NUM_OUT_W-1:0] entered_number;

   kpse_scan #(.DEBOUNCE_WIDTH(DEBOUNCE_WIDTH)) u_scan (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .column_levels (in_cols_ff),
      .debounce_ticks(deb_ticks_ff),
      .row_drive     (row_drive),
      .key_evt       (key_evt)
   );

   kpse_number #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_number (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .key_evt       (key_evt),
      .enter_key     (enter_key_ff),
      .backspace_key (bksp_key_ff),
      .number_ready  (number_ready),
      .entered_number(entered_number)
   );

   // result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {1'b0, entered_number, key_evt.code, key_evt.pos, row_drive};
         rsp_user_ff <= {number_ready, key_evt.valid};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== test/keypad_scan_number_entry_core_tb.sv =====
// Testbench for the keypad scanner with number entry: emulated 4x4 key matrix, self-checking.
module keypad_scan_number_entry_core_tb
   import kpse_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // Key matrix as the block should decode it: row*4+col -> code.
   localparam logic [CODE_W-1:0] KEY_CODES [16] = '{
      7'd1,  7'd2, 7'd3,  7'd65,
      7'd4,  7'd5, 7'd6,  7'd66,
      7'd7,  7'd8, 7'd9,  7'd67,
      7'd12, 7'd0, 7'd14, 7'd15
   };
   localparam int DIGIT_MAX   = 9;
   localparam int SHOW_LIMIT  = 40;   // mismatch lines printed before going quiet

   // One response as it should leave the block.
   typedef struct packed {
      logic [ROW_W-1:0]     drive;
      logic                 key_event;
      logic [POS_W-1:0]     pos;
      logic [CODE_W-1:0]    code;
      logic                 ready;
      logic [NUM_OUT_W-1:0] number;
   } scan_result_type;

   // Mirror of the scanner and the number being typed. step() runs one request,
   // compare_response() checks what came out against the oldest result due.
   class keypad_entry_mirror;
      logic [TICKS_W-1:0]   debounce_ticks = 20'd50000;
      logic [KEYIDX_W-1:0]  enter_pos      = 4'd14;
      logic [KEYIDX_W-1:0]  backspace_pos  = 4'd11;
      phase_type            phase          = PH_WAIT_PRESS;
      logic [TICKS_W-1:0]   settle_count   = '0;
      logic [1:0]           scan_row       = '0;
      logic [POS_W-1:0]     found_pos      = '0;
      logic [NUM_OUT_W-1:0] number_acc     = '0;
      logic [ROW_W-1:0]     row_drive      = '0;   // rows applied while the next request is sampled
      scan_result_type      due_results[$];
      int                   mismatches, responses, key_events, numbers_done;

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_DEBOUNCE_TICKS: debounce_ticks = value[TICKS_W-1:0];
            CSR_ENTER_KEY:      enter_pos      = value[KEYIDX_W-1:0];
            CSR_BACKSPACE_KEY:  backspace_pos  = value[KEYIDX_W-1:0];
            default: ;
         endcase
      endfunction

      // Debounce lasts ticks+1 steps; an all-ones counter also ends it.
      function bit debounce_over();
         if (settle_count >= debounce_ticks || settle_count == '1) return 1'b1;
         settle_count++;
         return 1'b0;
      endfunction

      function void step(logic [COL_W-1:0] cols);
         logic [COL_W-1:0] lows;
         logic [1:0]       col;
         scan_result_type  r;
         lows = ~cols;
         r    = '0;
         col  = '0;
         case (phase)
            PH_WAIT_PRESS:
               if (lows != 0) begin
                  phase        = PH_DEB_PRESS;
                  settle_count = '0;
               end
            PH_DEB_PRESS:
               if (debounce_over()) begin
                  phase    = PH_SCAN;
                  scan_row = '0;
               end
            PH_SCAN:
               if (lows != 0) begin
                  for (int c = COL_W - 1; c >= 0; c--) if (lows[c]) col = 2'(c);
                  found_pos = {scan_row, col};
                  phase     = PH_WAIT_RELEASE;
               end else begin
                  scan_row = scan_row + 2'd1;
               end
            PH_WAIT_RELEASE:
               if (lows == 0) begin
                  phase        = PH_DEB_RELEASE;
                  settle_count = '0;
               end
            PH_DEB_RELEASE:
               if (debounce_over()) begin
                  phase       = PH_WAIT_PRESS;
                  r.key_event = 1'b1;
                  r.pos       = found_pos;
                  r.code      = KEY_CODES[found_pos];
                  key_events++;
                  // enter beats backspace beats digit
                  if (found_pos == enter_pos) begin
                     r.ready    = 1'b1;
                     r.number   = number_acc;
                     number_acc = '0;
                     numbers_done++;
                  end else if (found_pos == backspace_pos) begin
                     number_acc = number_acc / 10;
                  end else if (r.code <= DIGIT_MAX) begin
                     number_acc = number_acc * 32'd10 + 32'(r.code);
                  end
               end
            default: phase = PH_WAIT_PRESS;
         endcase
         if (phase == PH_SCAN || phase == PH_WAIT_RELEASE || phase == PH_DEB_RELEASE)
            r.drive = ~(4'b0001 << scan_row);
         row_drive = r.drive;
         due_results.push_back(r);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         if (mismatches <= SHOW_LIMIT)
            $display("mismatch on response %0d, %s: got 0x%0h, want 0x%0h",
                     responses, what, got, want);
      endtask

      task compare_response(logic [RSP_DATA_W-1:0] data, logic [RSP_USER_W-1:0] user);
         scan_result_type want;
         responses++;
         if (due_results.size() == 0) begin
            report("response with nothing due", data[31:0], 0);
            return;
         end
         want = due_results.pop_front();
         if (data[3:0]   !== want.drive)     report("row_drive", data[3:0], want.drive);
         if (data[7:4]   !== want.pos)       report("key_position", data[7:4], want.pos);
         if (data[14:8]  !== want.code)      report("key_code", data[14:8], want.code);
         if (data[46:15] !== want.number)    report("entered_number", data[46:15], want.number);
         if (user[0]     !== want.key_event) report("key_event", user[0], want.key_event);
         if (user[1]     !== want.ready)     report("number_ready", user[1], want.ready);
      endtask
   endclass

   // A finger on the keypad: keys held (several may be down at once), how long,
   // then a pause before the next stroke. hold < 0 means hold until the scan finds it.
   typedef struct {
      logic [15:0] keys;
      int          hold;
      int          gap;
   } keystroke_type;

   typedef enum {STROKE_NONE, STROKE_HOLD, STROKE_RELEASE, STROKE_GAP} stroke_stage_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '1;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   keypad_entry_mirror entry = new();

   keystroke_type    stroke_plan[$];
   keystroke_type    cur_stroke;
   stroke_stage_type stroke_stage = STROKE_NONE;
   int               stroke_ticks = 0;
   int               rx_idle_pct  = 0;
   int               settings_used = 0;

   keypad_scan_number_entry_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Response side: check every accepted response, stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         entry.compare_response(rsp_tdata, rsp_tuser);
      rsp_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
   end

   function automatic logic [15:0] key_at(int pos);
      return 16'b1 << pos;
   endfunction

   function automatic logic [15:0] random_digit_key();
      int p;
      do p = $urandom_range(15); while (KEY_CODES[p] > DIGIT_MAX);
      return key_at(p);
   endfunction

   function automatic void queue_stroke(logic [15:0] keys, int hold);
      keystroke_type s;
      s.keys = keys;
      s.hold = hold;
      s.gap  = ($urandom_range(7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 2);
      stroke_plan.push_back(s);
   endfunction

   // Mostly whole numbers typed and entered; the rest are odd keys, chords and
   // presses short enough that some fail the debounce (those leave the scan wrapping).
   function automatic void plan_strokes(bit winding);
      int kind;
      int digits;
      int short_max;
      if (winding) begin
         queue_stroke(random_digit_key(), -1);
         return;
      end
      kind = $urandom_range(99);
      if (kind < 70) begin
         // long runs can overflow the 32-bit number
         digits = ($urandom_range(5) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 6);
         for (int i = 0; i < digits; i++)
            if ($urandom_range(9) == 0) queue_stroke(key_at(entry.backspace_pos), -1);
            else                        queue_stroke(random_digit_key(), -1);
         queue_stroke(key_at(entry.enter_pos), -1);
      end else if (kind < 82) begin
         queue_stroke(key_at($urandom_range(15)), -1);
      end else if (kind < 92) begin
         queue_stroke(key_at($urandom_range(15)) | key_at($urandom_range(15))
                      | ($urandom_range(1) ? key_at($urandom_range(15)) : 16'h0), -1);
      end else begin
         short_max = (entry.debounce_ticks > 20) ? 22 : int'(entry.debounce_ticks) + 2;
         queue_stroke(key_at($urandom_range(15)), $urandom_range(0, short_max));
      end
   endfunction

   // Column levels for the next request: a held key pulls its column low when
   // its row is driven low; noise and contact bounce flip bits at random.
   function automatic logic [COL_W-1:0] next_columns(bit noisy, bit winding);
      logic [COL_W-1:0] cols;
      logic [15:0]      keys;
      int               noise_pct;
      if (stroke_stage == STROKE_NONE) begin
         if (stroke_plan.size() == 0) plan_strokes(winding);
         cur_stroke   = stroke_plan.pop_front();
         stroke_stage = STROKE_HOLD;
         stroke_ticks = 0;
      end
      keys = (stroke_stage == STROKE_HOLD) ? cur_stroke.keys : 16'h0;
      cols = '1;
      for (int r = 0; r < ROW_W; r++)
         for (int c = 0; c < COL_W; c++)
            if (!entry.row_drive[r] && keys[4*r+c]) cols[c] = 1'b0;
      noise_pct = (stroke_ticks < 2 && stroke_stage != STROKE_GAP) ? 40 : 4;
      if (noisy && $urandom_range(99) < noise_pct) cols ^= 4'($urandom_range(15));
      return cols;
   endfunction

   // Move the finger on once a request has gone in, looking at the mirrored phase.
   function automatic void advance_stroke();
      stroke_ticks++;
      case (stroke_stage)
         STROKE_HOLD:
            if (cur_stroke.hold >= 0 ? stroke_ticks >= cur_stroke.hold
                                     : entry.phase == PH_WAIT_RELEASE) begin
               stroke_stage = STROKE_RELEASE;
               stroke_ticks = 0;
            end
         STROKE_RELEASE:
            if (entry.phase == PH_WAIT_PRESS || entry.phase == PH_SCAN) begin
               stroke_stage = STROKE_GAP;
               stroke_ticks = 0;
            end
         default: ;
      endcase
      if (stroke_stage == STROKE_GAP && stroke_ticks >= cur_stroke.gap)
         stroke_stage = STROKE_NONE;
   endfunction

   task automatic wait_drained();
      while (entry.due_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      entry.write_reg(idx, value);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Registers change only with nothing in flight.
   task automatic apply_settings(input logic [TICKS_W-1:0] ticks,
                                 input logic [KEYIDX_W-1:0] enter_key,
                                 input logic [KEYIDX_W-1:0] backspace_key);
      wait_drained();
      repeat (2) @(posedge clock);
      csr_write(CSR_DEBOUNCE_TICKS, CSR_DATA_W'(ticks));
      csr_write(CSR_ENTER_KEY, CSR_DATA_W'(enter_key));
      csr_write(CSR_BACKSPACE_KEY, CSR_DATA_W'(backspace_key));
      settings_used++;
   endtask

   // Send requests from the keypad emulation. Stops after min_items once the
   // plan is used up; with settle set, only between strokes with the scanner
   // back to waiting for a press. A noisy run pauses once until drained.
   task automatic run_keypad(input int min_items, input int tx_idle,
                             input bit noisy, input bit settle);
      int               sent;
      bit               pending;
      bit               paused;
      bit               done;
      logic [COL_W-1:0] cols;
      sent    = 0;
      pending = 1'b0;
      paused  = 1'b0;
      done    = 1'b0;
      while (!done) begin
         @(posedge clock);
         if (pending && req_tready === 1'b1) begin
            entry.step(req_tdata[COL_W-1:0]);
            advance_stroke();
            sent++;
            pending = 1'b0;
         end
         if (pending) continue;
         if (noisy && !paused && sent == min_items / 2) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            wait_drained();
         end else if (sent >= min_items && stroke_plan.size() == 0 &&
                      (!settle || (stroke_stage == STROKE_NONE &&
                                   entry.phase == PH_WAIT_PRESS))) begin
            req_tvalid <= 1'b0;
            done = 1'b1;
         end else if (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
            req_tvalid <= 1'b0;
         end else begin
            cols = next_columns(noisy && sent < min_items, sent >= min_items);
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_DATA_W'(cols);
            pending = 1'b1;
         end
      end
   endtask

   initial begin
      int                  tx_idle;
      logic [TICKS_W-1:0]  ticks;
      logic [KEYIDX_W-1:0] enter_key;
      logic [KEYIDX_W-1:0] backspace_key;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // A few idle requests at reset values: rows all low, nothing reported.
      queue_stroke(16'h0000, 3);
      run_keypad(0, 0, 1'b0, 1'b1);

      // Directed: backspace on an empty number, a key in row 0, a chord in
      // row 1 (lowest column wins), the zero key in row 3, backspace, enter.
      apply_settings(20'd0, 4'd14, 4'd11);
      queue_stroke(key_at(11), -1);
      queue_stroke(key_at(0), -1);
      queue_stroke(key_at(5) | key_at(6), -1);
      queue_stroke(key_at(13), -1);
      queue_stroke(key_at(11), -1);
      queue_stroke(key_at(14), -1);
      run_keypad(0, 0, 1'b0, 1'b1);

      // Random typing under several settings; index extremes, enter and
      // backspace on one key, and both roles placed on digit keys.
      for (int p = 0; p < 6; p++) begin
         if (p < 2) begin
            tx_idle     = 31;
            rx_idle_pct = 46;
         end else if (p < 4) begin
            tx_idle     = 46;
            rx_idle_pct = 31;
         end else begin
            tx_idle     = 0;
            rx_idle_pct = 0;
         end
         case (p)
            0: begin ticks = 20'd1; enter_key = 4'd14; backspace_key = 4'd11; end
            1: begin ticks = 20'd0; enter_key = 4'd0;  backspace_key = 4'd15; end
            2: begin ticks = 20'd2; enter_key = 4'd7;  backspace_key = 4'd7;  end
            3: begin ticks = 20'd3; enter_key = 4'd5;  backspace_key = 4'd1;  end
            4: begin ticks = 20'd4; enter_key = 4'd15; backspace_key = 4'd0;  end
            default: begin
               ticks         = TICKS_W'($urandom_range(5, 9));
               enter_key     = 4'($urandom_range(15));
               backspace_key = 4'($urandom_range(15));
            end
         endcase
         apply_settings(ticks, enter_key, backspace_key);
         run_keypad(60, tx_idle, 1'b1, 1'b1);
      end

      // Longest debounce: a long press stays inside the first debounce wait.
      rx_idle_pct = 0;
      apply_settings(20'hFFFFF, 4'd14, 4'd11);
      queue_stroke(key_at(5), 1000);
      run_keypad(50, 0, 1'b0, 1'b0);

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Checked %0d responses under %0d register settings.",
               entry.responses, settings_used);
      $display("Keys completed: %0d, numbers entered: %0d, mismatches: %0d.",
               entry.key_events, entry.numbers_done, entry.mismatches);
      if (entry.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #5ms;
      $display("Timeout with %0d responses outstanding.", entry.due_results.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
